>>> design/rcppm_pkg.sv
// Shared constants, types and codes of the PPM frame generator.
`timescale 1ns / 1ps
package rcppm_pkg;

   localparam int CHANNELS      = 9;
   localparam int REPORT_FIELDS = 9;
   localparam int WIDTH_W       = 8;
   localparam int GAP_W         = 8;
   localparam int IDLE_W        = 12;
   localparam int TICK_W        = 12;
   localparam int SEGMENT_W     = 5;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 12;

   // Internal segment index: 0 idle, odd gaps, even channel pulses.
   localparam int LAST_SEG  = 2 * CHANNELS + 1;
   localparam int SEG_W     = $clog2(LAST_SEG + 1);
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [GAP_W-1:0]   GAP_RESET   = GAP_W'(36);
   localparam logic [IDLE_W-1:0]  IDLE_RESET  = IDLE_W'(600);
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1);

   // A zero width or zero gap lasts 256 ticks, one full wrap of an 8-bit field.
   localparam logic [TICK_W-1:0]  ZERO_WIDTH_TICKS = TICK_W'(256);

   typedef enum logic {
      OP_TICK   = 1'b0,
      OP_REPORT = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAP_TICKS  = 1'b0,
      CSR_IDLE_TICKS = 1'b1
   } csr_index_type;

   typedef logic [REPORT_FIELDS-1:0][WIDTH_W-1:0] report_widths_type;
   typedef logic [CHANNELS-1:0][WIDTH_W-1:0]      channel_widths_type;

   typedef struct packed {
      op_type            op;
      report_widths_type widths;
   } request_type;

   typedef struct packed {
      logic                 ppm_line;
      logic [SEGMENT_W-1:0] segment;
      logic                 frame_done;
   } result_type;

endpackage

>>> design/rcppm_req_if.sv
// Request channel of the PPM frame generator: a tick or a channel report.
`timescale 1ns / 1ps
interface rcppm_req_if;
   import rcppm_pkg::*;

   logic               valid;
   logic               ready;
   logic               op;
   logic [WIDTH_W-1:0] ch1;
   logic [WIDTH_W-1:0] ch2;
   logic [WIDTH_W-1:0] ch3;
   logic [WIDTH_W-1:0] ch4;
   logic [WIDTH_W-1:0] ch5;
   logic [WIDTH_W-1:0] ch6;
   logic [WIDTH_W-1:0] ch7;
   logic [WIDTH_W-1:0] ch8;
   logic [WIDTH_W-1:0] ch9;

   modport source (
      output valid, op, ch1, ch2, ch3, ch4, ch5, ch6, ch7, ch8, ch9,
      input  ready
   );

   modport sink (
      input  valid, op, ch1, ch2, ch3, ch4, ch5, ch6, ch7, ch8, ch9,
      output ready
   );

endinterface

>>> design/rcppm_rsp_if.sv
// Result channel of the PPM frame generator: line level and segment per request.
`timescale 1ns / 1ps
interface rcppm_rsp_if;
   import rcppm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 ppm_line;
   logic [SEGMENT_W-1:0] segment;
   logic                 frame_done;

   modport source (
      output valid, ppm_line, segment, frame_done,
      input  ready
   );

   modport sink (
      input  valid, ppm_line, segment, frame_done,
      output ready
   );

endinterface

>>> design/rcppm_input_stage.sv
// Input register of the PPM frame generator.
`timescale 1ns / 1ps
module rcppm_input_stage (
   input  logic                   clock,
   input  logic                   reset,
   rcppm_req_if.sink              req,
   input  logic                   advance,
   output logic                   item_valid,
   output rcppm_pkg::request_type item
);
   import rcppm_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   request_type item_ff;
   request_type item_in;
   logic        take;

   // A new request enters when the register is empty or drains this cycle.
   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      item_in           = item_ff;
      if (take) begin
         item_in.op        = op_type'(req.op);
         item_in.widths[0] = req.ch1;
         item_in.widths[1] = req.ch2;
         item_in.widths[2] = req.ch3;
         item_in.widths[3] = req.ch4;
         item_in.widths[4] = req.ch5;
         item_in.widths[5] = req.ch6;
         item_in.widths[6] = req.ch7;
         item_in.widths[7] = req.ch8;
         item_in.widths[8] = req.ch9;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> design/rcppm_frame_core.sv
// Frame state, timing registers and next-result logic of the PPM generator.
`timescale 1ns / 1ps
module rcppm_frame_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rcppm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rcppm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                                fire,
   input  rcppm_pkg::request_type              item,
   output rcppm_pkg::result_type               result
);
   import rcppm_pkg::*;

   logic [GAP_W-1:0]   gap_ticks_ff;
   logic [GAP_W-1:0]   gap_ticks_in;
   logic [IDLE_W-1:0]  idle_ticks_ff;
   logic [IDLE_W-1:0]  idle_ticks_in;

   logic               enabled_ff;
   logic               enabled_in;
   logic               line_ff;
   logic               line_in;
   logic [SEG_W-1:0]   seg_ff;
   logic [SEG_W-1:0]   seg_in;
   logic [TICK_W-1:0]  tick_ff;
   logic [TICK_W-1:0]  tick_in;
   channel_widths_type widths_ff;
   channel_widths_type widths_in;
   channel_widths_type pending_ff;
   channel_widths_type pending_in;
   logic               pending_valid_ff;
   logic               pending_valid_in;

   logic [SEG_W-1:0]    seg_offset;
   logic [CH_IDX_W-1:0] ch_idx;
   logic [WIDTH_W-1:0]  ch_width;
   logic [TICK_W-1:0]   seg_len;
   logic [TICK_W-1:0]   tick_next;
   logic [SEG_W-1:0]    seg_next;
   logic                done;

   // Configuration writes; a new length applies from the next count compare.
   always_comb begin
      gap_ticks_in  = gap_ticks_ff;
      idle_ticks_in = idle_ticks_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_GAP_TICKS:  gap_ticks_in  = csr_write_data[GAP_W-1:0];
            CSR_IDLE_TICKS: idle_ticks_in = csr_write_data[IDLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Channel pulse 2c+2 reads width c.
   assign seg_offset = seg_ff - SEG_W'(2);
   assign ch_idx     = CH_IDX_W'(seg_offset >> 1);
   assign ch_width   = widths_ff[ch_idx];

   always_comb begin
      if (seg_ff == '0) begin
         seg_len = (idle_ticks_ff == '0) ? TICK_W'(1) : TICK_W'(idle_ticks_ff);
      end else if (seg_ff[0]) begin
         seg_len = (gap_ticks_ff == '0) ? ZERO_WIDTH_TICKS : TICK_W'(gap_ticks_ff);
      end else begin
         seg_len = (ch_width == '0) ? ZERO_WIDTH_TICKS : TICK_W'(ch_width);
      end
   end

   assign tick_next = tick_ff + TICK_W'(1);
   assign seg_next  = seg_ff + SEG_W'(1);

   always_comb begin
      enabled_in       = enabled_ff;
      line_in          = line_ff;
      seg_in           = seg_ff;
      tick_in          = tick_ff;
      widths_in        = widths_ff;
      pending_in       = pending_ff;
      pending_valid_in = pending_valid_ff;
      done             = 1'b0;

      if (fire) begin
         if (item.op == OP_REPORT) begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (i < REPORT_FIELDS) begin
                  pending_in[i] = item.widths[i];
               end
            end
            pending_valid_in = 1'b1;
            enabled_in       = 1'b1;
         end else if (enabled_ff) begin
            if (tick_next < seg_len) begin
               tick_in = tick_next;
            end else begin
               tick_in = '0;
               if (seg_ff >= SEG_W'(LAST_SEG)) begin
                  seg_in  = '0;
                  line_in = 1'b1;
                  done    = 1'b1;
               end else begin
                  seg_in  = seg_next;
                  line_in = !seg_next[0];
                  // New widths take effect as the frame leaves idle.
                  if (seg_next == SEG_W'(1) && pending_valid_ff) begin
                     widths_in        = pending_ff;
                     pending_valid_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff     <= GAP_RESET;
         idle_ticks_ff    <= IDLE_RESET;
         enabled_ff       <= 1'b0;
         line_ff          <= 1'b0;
         seg_ff           <= '0;
         tick_ff          <= '0;
         widths_ff        <= {CHANNELS{WIDTH_RESET}};
         pending_ff       <= {CHANNELS{WIDTH_RESET}};
         pending_valid_ff <= 1'b0;
      end else begin
         gap_ticks_ff     <= gap_ticks_in;
         idle_ticks_ff    <= idle_ticks_in;
         enabled_ff       <= enabled_in;
         line_ff          <= line_in;
         seg_ff           <= seg_in;
         tick_ff          <= tick_in;
         widths_ff        <= widths_in;
         pending_ff       <= pending_in;
         pending_valid_ff <= pending_valid_in;
      end
   end

   assign result.ppm_line   = line_in;
   assign result.segment    = SEGMENT_W'(seg_in);
   assign result.frame_done = done;

endmodule

>>> design/rcppm_output_stage.sv
// Result register of the PPM frame generator.
`timescale 1ns / 1ps
module rcppm_output_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  rcppm_pkg::result_type result,
   output logic                  advance,
   rcppm_rsp_if.source           rsp
);
   import rcppm_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   result_type result_in;

   // The register can take a new result when empty or being read out.
   assign advance = !valid_ff || rsp.ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (fire) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp.valid      = valid_ff;
   assign rsp.ppm_line   = result_ff.ppm_line;
   assign rsp.segment    = result_ff.segment;
   assign rsp.frame_done = result_ff.frame_done;

endmodule

>>> design/rc_ppm_frame_generator_unit.sv
// A request's result is held in the result register after it passes the input
// register and the frame core; a stall on the result side holds it there.
// Throughput: one request per cycle unless the result side stalls; the frame
// counter compare and segment step between input and result register set that rate.
// Reset (synchronous, active high): generator disabled, line low, idle segment,
// all channel widths 1, gap 36 ticks, idle 600 ticks, both stages empty.
`timescale 1ns / 1ps
module rc_ppm_frame_generator_unit (
   input  logic                              clock,
   input  logic                              reset,
   rcppm_req_if.sink                         req,
   rcppm_rsp_if.source                       rsp,
   input  logic                              csr_write_enable,
   input  logic [rcppm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcppm_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import rcppm_pkg::*;

   logic        advance;
   logic        item_valid;
   logic        fire;
   request_type item;
   result_type  result;

   assign fire = item_valid && advance;

   rcppm_input_stage u_input_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   rcppm_frame_core u_frame_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fire             (fire),
      .item             (item),
      .result           (result)
   );

   rcppm_output_stage u_output_stage (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .result  (result),
      .advance (advance),
      .rsp     (rsp)
   );

endmodule
